/* src/dstt_pkg.sv */
// Shared types and constants for the dual sensor transit timer.
package dstt_pkg;

   localparam int BLOCK_SAMPLES_DEF = 16;
   localparam int SAMPLE_BITS_DEF   = 12;
   localparam int CSR_IDX_BITS      = 3;
   localparam int CSR_DATA_BITS     = 24;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BASELINE_BLOCKS  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_BASELINE_SUM = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DRIFT_LIMIT      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRACE_SCALE      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRACE2_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FREEZE1_DELAY    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FREEZE2_DELAY    = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FREEZE_HOLD      = 3'd7;

   // divider width: 24-bit numerators, 16-bit divisors
   localparam int DIV_BITS = 24;

   typedef struct packed {
      logic [11:0] sample_one;
      logic [11:0] sample_two;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] trace_one;
      logic        trace_one_write;
      logic [15:0] trace_two;
      logic        trace_two_write;
      logic        baseline_ready;
      logic        transit_done;
      logic [31:0] transit_ms;
      logic [15:0] baseline_one_value;
      logic [15:0] baseline_two_value;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] num;
      logic [15:0]         den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quo;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_B1,
      ST_DIV_B2,
      ST_DIV_T1,
      ST_DIV_T2,
      ST_FINISH,
      ST_OUT
   } state_type;

endpackage

/* src/dstt_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by all block divisions.
module dstt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  dstt_pkg::div_req_type div_req,
   output dstt_pkg::div_rsp_type div_rsp
);

   localparam int W = dstt_pkg::DIV_BITS;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [16:0]   rem_ff, rem_in;
   logic [15:0]   den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [16:0]   trial;

   // shift in one numerator bit and try the subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[W-1]};
      if (div_req.start) begin
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_cnt_zero_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |=> !busy_ff || $past(div_req.start))
      else $error("divider woke without start");
`endif

endmodule

/* src/dual_sensor_transit_timer.sv */
// Top level of the dual sensor transit timer: accumulation, sequencer, output register.
//
// Usage:
//  The req_ channel takes one paired sample (sample_one, sample_two, time_ms) a
//  beat. Every BLOCK_SAMPLES samples close a block and give one rsp_ beat; the
//  other samples give none. The csr_ port writes the eight registers by index;
//  the user must write them only while the block is idle; the block does not enforce it.
//  Flow: a sample that does not close a block is taken while req_stall stays low.
//  A block-closing sample runs a sequencer over one shared restoring divider: four
//  divisions (two baselines, two traces) of 24 quotient bits each (ST_DIV_B1,
//  ST_DIV_B2, ST_DIV_T1, ST_DIV_T2), then ST_FINISH latches the result beat and
//  ST_OUT returns to ST_IDLE; req_stall stays high until then, so no new sample is
//  taken mid-sequence. The shared divider's one-bit-per-cycle loop sets its length.
//  Reset (synchronous, active high) returns all registers to their defaults and
//  clears every block, window, baseline and dip state; no clearing pass.
//  If the receiver stalls, the result beat holds in the output register and new
//  samples are taken until another block would close, which then waits.
module dual_sensor_transit_timer #(
   parameter int BLOCK_SAMPLES = dstt_pkg::BLOCK_SAMPLES_DEF,
   parameter int SAMPLE_BITS   = dstt_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dstt_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dstt_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write,
   input  logic [dstt_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dstt_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int PW = 4;
   localparam logic [PW-1:0] LAST_PHASE = PW'(BLOCK_SAMPLES - 1);

   // configuration registers
   logic [7:0]  cfg_blocks_ff, cfg_scale_ff, cfg_offset_ff;
   logic [23:0] cfg_min_ff;
   logic [15:0] cfg_drift_ff;
   logic [6:0]  cfg_fd1_ff, cfg_fd2_ff;
   logic [9:0]  cfg_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_blocks_ff <= 8'd200;
         cfg_min_ff    <= 24'd5000;
         cfg_drift_ff  <= 16'd160;
         cfg_scale_ff  <= 8'd60;
         cfg_offset_ff <= 8'd3;
         cfg_fd1_ff    <= 7'd110;
         cfg_fd2_ff    <= 7'd60;
         cfg_hold_ff   <= 10'd1000;
      end else if (csr_write) begin
         unique case (csr_index)
            dstt_pkg::CSR_BASELINE_BLOCKS:  cfg_blocks_ff <= csr_data[7:0];
            dstt_pkg::CSR_MIN_BASELINE_SUM: cfg_min_ff    <= csr_data;
            dstt_pkg::CSR_DRIFT_LIMIT:      cfg_drift_ff  <= csr_data[15:0];
            dstt_pkg::CSR_TRACE_SCALE:      cfg_scale_ff  <= csr_data[7:0];
            dstt_pkg::CSR_TRACE2_OFFSET:    cfg_offset_ff <= csr_data[7:0];
            dstt_pkg::CSR_FREEZE1_DELAY:    cfg_fd1_ff    <= csr_data[6:0];
            dstt_pkg::CSR_FREEZE2_DELAY:    cfg_fd2_ff    <= csr_data[6:0];
            dstt_pkg::CSR_FREEZE_HOLD:      cfg_hold_ff   <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // state
   dstt_pkg::state_type state_ff, state_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [15:0] bs1_ff, bs1_in, bs2_ff, bs2_in;
   logic [23:0] ws1_ff, ws1_in, ws2_ff, ws2_in;
   logic [7:0]  wcnt_ff, wcnt_in;
   logic [15:0] base1_ff, base1_in, base2_ff, base2_in;
   logic        known1_ff, known1_in, known2_ff, known2_in;
   logic [15:0] thr1_ff, thr1_in, thr2_ff, thr2_in;
   logic        dip1_ff, dip1_in, dip2_ff, dip2_in, wait2_ff, wait2_in;
   logic [31:0] dt1_ff, dt1_in, dt2_ff, dt2_in, last_ff, last_in;
   logic [6:0]  dly1_ff, dly1_in, dly2_ff, dly2_in;
   logic [9:0]  frz1_ff, frz1_in, frz2_ff, frz2_in;
   logic [31:0] now_ff, now_in;
   logic        close1_ff, close1_in, close2_ff, close2_in;
   logic [15:0] t1_ff, t1_in, t2_ff, t2_in;
   logic        ov_ff, ov_in;
   dstt_pkg::rsp_type rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   dstt_pkg::div_req_type div_req;
   dstt_pkg::div_rsp_type div_rsp;

   dstt_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic        accept;
   logic [15:0] s1_ext, s2_ext;
   logic [24:0] add1, add2;
   logic [7:0]  wcnt_inc;
   logic [15:0] dev;
   logic [23:0] prod1, prod2;
   logic [23:0] q2off;

   assign req_stall = (state_ff != dstt_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign s1_ext = 16'(req_data.sample_one[SAMPLE_BITS-1:0]);
   assign s2_ext = 16'(req_data.sample_two[SAMPLE_BITS-1:0]);

   // threshold: 9/10 of baseline, divide by ten through a reciprocal multiply
   function automatic logic [15:0] nine_tenths(input logic [15:0] b);
      logic [19:0] m;
      logic [39:0] p;
      m = 20'(b) * 20'd9;
      // ceil(2^23 / 10) is exact for every value below 2^22
      p = 40'(m) * 40'd838861;
      return p[38:23];
   endfunction

   // sequencer: accumulate, run baseline and trace divisions, then track drift and dips and latch the beat
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      bs1_in = bs1_ff; bs2_in = bs2_ff;
      ws1_in = ws1_ff; ws2_in = ws2_ff; wcnt_in = wcnt_ff;
      base1_in = base1_ff; base2_in = base2_ff;
      known1_in = known1_ff; known2_in = known2_ff;
      thr1_in = thr1_ff; thr2_in = thr2_ff;
      dip1_in = dip1_ff; dip2_in = dip2_ff; wait2_in = wait2_ff;
      dt1_in = dt1_ff; dt2_in = dt2_ff; last_in = last_ff;
      dly1_in = dly1_ff; dly2_in = dly2_ff; frz1_in = frz1_ff; frz2_in = frz2_ff;
      now_in = now_ff;
      close1_in = close1_ff; close2_in = close2_ff;
      t1_in = t1_ff; t2_in = t2_ff; ov_in = ov_ff;
      rsp_in = rsp_ff;
      rspv_in = rspv_ff && rsp_stall;
      div_req = '0;
      add1 = '0; add2 = '0; wcnt_inc = wcnt_ff; dev = '0;
      prod1 = 24'(bs1_ff) * 24'(cfg_scale_ff);
      prod2 = 24'(bs2_ff) * 24'(cfg_scale_ff);
      q2off = '0;
      unique case (state_ff)
         dstt_pkg::ST_IDLE: begin
            if (accept) begin
               bs1_in = bs1_ff + s1_ext;
               bs2_in = bs2_ff + s2_ext;
               now_in = req_data.time_ms;
               if (phase_ff == LAST_PHASE || BLOCK_SAMPLES == 1) begin
                  phase_in = '0;
                  add1 = 25'(ws1_ff) + 25'(bs1_in);
                  add2 = 25'(ws2_ff) + 25'(bs2_in);
                  ws1_in = add1[24] ? 24'hFFFFFF : add1[23:0];
                  ws2_in = add2[24] ? 24'hFFFFFF : add2[23:0];
                  if (wcnt_ff != 8'd255) wcnt_inc = wcnt_ff + 8'd1;
                  wcnt_in = wcnt_inc;
                  close1_in = 1'b0; close2_in = 1'b0;
                  if (wcnt_inc >= cfg_blocks_ff) begin
                     close1_in = ws1_in > cfg_min_ff;
                     close2_in = ws2_in > cfg_min_ff;
                  end
                  state_in = dstt_pkg::ST_DIV_B1;
                  div_req.start = 1'b1;
                  div_req.num   = ws1_in;
                  div_req.den   = 16'(wcnt_inc);
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
            end
         end
         dstt_pkg::ST_DIV_B1: begin
            if (div_rsp.done) begin
               if (close1_ff) begin
                  base1_in = div_rsp.quo[15:0];
                  thr1_in = nine_tenths(base1_in);
                  known1_in = 1'b1;
               end
               state_in = dstt_pkg::ST_DIV_B2;
               div_req.start = 1'b1;
               div_req.num   = ws2_ff;
               div_req.den   = 16'(wcnt_ff);
            end
         end
         dstt_pkg::ST_DIV_B2: begin
            if (div_rsp.done) begin
               if (close2_ff) begin
                  base2_in = div_rsp.quo[15:0];
                  thr2_in = nine_tenths(base2_in);
                  known2_in = 1'b1;
               end
               if (wcnt_ff >= cfg_blocks_ff) begin
                  wcnt_in = '0; ws1_in = '0; ws2_in = '0;
               end
               state_in = dstt_pkg::ST_DIV_T1;
               div_req.start = 1'b1;
               div_req.num   = prod1;
               div_req.den   = base1_in;
            end
         end
         dstt_pkg::ST_DIV_T1: begin
            if (div_rsp.done) begin
               t1_in = (base1_ff == 16'd0 || div_rsp.quo[23:16] != 8'd0) ?
                       16'hFFFF : div_rsp.quo[15:0];
               state_in = dstt_pkg::ST_DIV_T2;
               div_req.start = 1'b1;
               div_req.num   = prod2;
               div_req.den   = base2_ff;
            end
         end
         dstt_pkg::ST_DIV_T2: begin
            if (div_rsp.done) begin
               if (base2_ff == 16'd0) begin
                  t2_in = 16'hFFFF;
               end else begin
                  q2off = (div_rsp.quo > 24'(cfg_offset_ff)) ?
                          div_rsp.quo - 24'(cfg_offset_ff) : 24'd0;
                  t2_in = (q2off[23:16] != 8'd0) ? 16'hFFFF : q2off[15:0];
               end
               state_in = dstt_pkg::ST_FINISH;
            end
         end
         dstt_pkg::ST_FINISH: begin
            // drift, dip tracking and freeze counters, then latch the beat
            rsp_in = '0;
            ov_in = 1'b0;
            if (known1_ff) begin
               dev = (bs1_ff > base1_ff) ? bs1_ff - base1_ff : base1_ff - bs1_ff;
               if (dev > cfg_drift_ff) begin
                  wcnt_in = '0; ws1_in = '0; ws2_in = '0;
               end
               rsp_in.trace_one = t1_ff;
               rsp_in.trace_two = known2_ff ? t2_ff : 16'd0;
               rsp_in.trace_one_write = (frz1_ff == 10'd0);
               rsp_in.trace_two_write = (frz2_ff == 10'd0);
               if (!wait2_ff) begin
                  if (dip1_ff) begin
                     if (bs1_ff > thr1_ff) begin
                        dip1_in = 1'b0; wait2_in = 1'b1;
                     end
                  end else if (bs1_ff <= thr1_ff) begin
                     dip1_in = 1'b1; dt1_in = now_ff;
                     if (dly1_ff == 7'd0) dly1_in = cfg_fd1_ff;
                  end
               end else begin
                  if (dip2_ff) begin
                     if (bs2_ff > thr2_ff) begin
                        dip2_in = 1'b0; wait2_in = 1'b0;
                        last_in = dt2_ff - dt1_ff;
                        ov_in = 1'b1;
                     end
                  end else if (bs2_ff <= thr2_ff) begin
                     dip2_in = 1'b1; dt2_in = now_ff;
                     if (dly2_ff == 7'd0) dly2_in = cfg_fd2_ff;
                  end
               end
            end
            bs1_in = '0; bs2_in = '0;
            if (dly1_in != 7'd0) begin
               dly1_in = dly1_in - 7'd1;
               if (dly1_in == 7'd0) frz1_in = 10'd1;
            end
            if (frz2_ff != 10'd0) begin
               frz2_in = frz2_ff - 10'd1;
               frz1_in = frz2_in;
            end
            if (dly2_in != 7'd0) begin
               dly2_in = dly2_in - 7'd1;
               if (dly2_in == 7'd0) frz2_in = cfg_hold_ff;
            end
            rsp_in.baseline_ready = known1_ff;
            rsp_in.transit_done = ov_in;
            rsp_in.transit_ms = last_in;
            rsp_in.baseline_one_value = base1_ff;
            rsp_in.baseline_two_value = base2_ff;
            if (!known1_ff) begin
               rsp_in.trace_one = '0; rsp_in.trace_two = '0;
            end
            state_in = dstt_pkg::ST_OUT;
            rsp_in = rspv_ff && rsp_stall ? rsp_ff : rsp_in;
            if (rspv_ff && rsp_stall) state_in = dstt_pkg::ST_FINISH;
            if (rspv_ff && rsp_stall) begin
               // redo next cycle: keep all state untouched
               wcnt_in = wcnt_ff; ws1_in = ws1_ff; ws2_in = ws2_ff;
               dip1_in = dip1_ff; dip2_in = dip2_ff; wait2_in = wait2_ff;
               dt1_in = dt1_ff; dt2_in = dt2_ff; last_in = last_ff;
               dly1_in = dly1_ff; dly2_in = dly2_ff;
               frz1_in = frz1_ff; frz2_in = frz2_ff;
               bs1_in = bs1_ff; bs2_in = bs2_ff;
            end else begin
               rspv_in = 1'b1;
            end
         end
         dstt_pkg::ST_OUT: begin
            state_in = dstt_pkg::ST_IDLE;
         end
         default: state_in = dstt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dstt_pkg::ST_IDLE;
         phase_ff <= '0;
         bs1_ff <= '0; bs2_ff <= '0; ws1_ff <= '0; ws2_ff <= '0; wcnt_ff <= '0;
         base1_ff <= '0; base2_ff <= '0; known1_ff <= 1'b0; known2_ff <= 1'b0;
         thr1_ff <= '0; thr2_ff <= '0;
         dip1_ff <= 1'b0; dip2_ff <= 1'b0; wait2_ff <= 1'b0;
         dt1_ff <= '0; dt2_ff <= '0; last_ff <= '0;
         dly1_ff <= '0; dly2_ff <= '0; frz1_ff <= '0; frz2_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         bs1_ff <= bs1_in; bs2_ff <= bs2_in;
         ws1_ff <= ws1_in; ws2_ff <= ws2_in; wcnt_ff <= wcnt_in;
         base1_ff <= base1_in; base2_ff <= base2_in;
         known1_ff <= known1_in; known2_ff <= known2_in;
         thr1_ff <= thr1_in; thr2_ff <= thr2_in;
         dip1_ff <= dip1_in; dip2_ff <= dip2_in; wait2_ff <= wait2_in;
         dt1_ff <= dt1_in; dt2_ff <= dt2_in; last_ff <= last_in;
         dly1_ff <= dly1_in; dly2_ff <= dly2_in; frz1_ff <= frz1_in; frz2_ff <= frz2_in;
         rspv_ff <= rspv_in;
      end
      now_ff <= now_in;
      close1_ff <= close1_in; close2_ff <= close2_in;
      t1_ff <= t1_in; t2_ff <= t2_in; ov_ff <= ov_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && rsp_stall |=> rspv_ff && $stable(rsp_ff))
      else $error("result beat changed under stall");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == dstt_pkg::ST_DIV_B1 |-> req_stall)
      else $error("sample taken during sequence");
   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && rsp_ff.transit_done |-> rsp_ff.baseline_ready)
      else $error("transit without baseline");
`endif

endmodule

/* tb/tb_dual_sensor_transit_timer.sv */
// Self-checking testbench for the dual sensor transit timer: directed blocks, then random phases.
`timescale 1ns / 100ps

module tb_dual_sensor_transit_timer;

   typedef enum logic [1:0] {
      SET_NONE,
      SET_LEARN,
      SET_ZERO_BASE
   } setting_type;

   typedef struct {
      setting_type       setting;
      logic [11:0]       s1;
      logic [11:0]       s2;
      logic [31:0]       t;
      int                rep;
      bit                typed;
      dstt_pkg::rsp_type want;
   } row_type;

   localparam int DRAIN_CYCLES = 150;
   localparam int IDX_BITS     = dstt_pkg::CSR_IDX_BITS;
   localparam int DATA_BITS    = dstt_pkg::CSR_DATA_BITS;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   dstt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   dstt_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [IDX_BITS-1:0]  csr_index = '0;
   logic [DATA_BITS-1:0] csr_data = '0;

   dstt_pkg::rsp_type pending_blocks[$];
   int      fails = 0;
   bit      quiet = 1'b0;

   // register copy held by the predictor
   logic [7:0]  cfg_blocks;
   logic [23:0] cfg_min_sum;
   logic [15:0] cfg_drift;
   logic [7:0]  cfg_scale;
   logic [7:0]  cfg_offset;
   logic [6:0]  cfg_delay1;
   logic [6:0]  cfg_delay2;
   logic [9:0]  cfg_hold;
   logic [23:0] next_cfg[8];

   // predictor state
   logic [3:0]  phase_cnt;
   logic [15:0] blk1, blk2;
   logic [23:0] win1, win2;
   logic [7:0]  win_cnt;
   logic [15:0] base1, base2, thr1, thr2;
   bit          known1, known2, dip1, dip2, want_second;
   logic [31:0] onset1, onset2, transit;
   logic [6:0]  delay1, delay2;
   logic [9:0]  frz1, frz2;

   dual_sensor_transit_timer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [23:0] sat24(logic [31:0] v);
      return v > 32'hFFFFFF ? 24'hFFFFFF : v[23:0];
   endfunction

   function automatic logic [31:0] scale_by_base(logic [15:0] sum, logic [15:0] base);
      logic [31:0] num;
      num = 32'(sum) * 32'(cfg_scale);
      return base == 16'd0 ? 32'hFFFFFFFF : num / 32'(base);
   endfunction

   function automatic void clear_predictor();
      cfg_blocks = 8'd200; cfg_min_sum = 24'd5000; cfg_drift = 16'd160; cfg_scale = 8'd60;
      cfg_offset = 8'd3; cfg_delay1 = 7'd110; cfg_delay2 = 7'd60; cfg_hold = 10'd1000;
      phase_cnt = '0; blk1 = '0; blk2 = '0; win1 = '0; win2 = '0; win_cnt = '0;
      base1 = '0; base2 = '0; thr1 = '0; thr2 = '0;
      known1 = 0; known2 = 0; dip1 = 0; dip2 = 0; want_second = 0;
      onset1 = '0; onset2 = '0; transit = '0;
      delay1 = '0; delay2 = '0; frz1 = '0; frz2 = '0;
   endfunction

   // advance the block model by one sample; return 1 when a block closes
   function automatic bit predict_block(dstt_pkg::req_type d, output dstt_pkg::rsp_type r);
      logic [31:0] dev, q, t1, t2;
      bit w1, w2, done;
      r = '0; t1 = '0; t2 = '0; w1 = 0; w2 = 0; done = 0;
      blk1 = blk1 + 16'(d.sample_one);
      blk2 = blk2 + 16'(d.sample_two);
      phase_cnt = phase_cnt + 4'd1;
      if (phase_cnt != 4'd0)
         return 0;
      win1 = sat24(32'(win1) + 32'(blk1));
      win2 = sat24(32'(win2) + 32'(blk2));
      if (win_cnt < 8'd255)
         win_cnt = win_cnt + 8'd1;
      // close the baseline window
      if (win_cnt >= cfg_blocks) begin
         if (win1 > cfg_min_sum) begin
            base1 = 16'(32'(win1) / 32'(win_cnt));
            thr1 = 16'(32'(base1) * 9 / 10);
            known1 = 1;
         end
         if (win2 > cfg_min_sum) begin
            base2 = 16'(32'(win2) / 32'(win_cnt));
            thr2 = 16'(32'(base2) * 9 / 10);
            known2 = 1;
         end
         win_cnt = '0; win1 = '0; win2 = '0;
      end
      if (known1) begin
         dev = blk1 > base1 ? 32'(blk1 - base1) : 32'(base1 - blk1);
         if (dev > 32'(cfg_drift)) begin
            win_cnt = '0; win1 = '0; win2 = '0;
         end
         q = scale_by_base(blk1, base1);
         t1 = q > 32'hFFFF ? 32'hFFFF : q;
         if (known2) begin
            q = scale_by_base(blk2, base2);
            q = q > 32'(cfg_offset) ? q - 32'(cfg_offset) : 32'd0;
            t2 = q > 32'hFFFF ? 32'hFFFF : q;
         end
         w1 = frz1 == '0;
         w2 = frz2 == '0;
         // dip tracking: sensor one first, then sensor two
         if (!want_second) begin
            if (dip1) begin
               if (blk1 > thr1) begin
                  dip1 = 0;
                  want_second = 1;
               end
            end else if (blk1 <= thr1) begin
               dip1 = 1;
               onset1 = d.time_ms;
               if (delay1 == '0)
                  delay1 = cfg_delay1;
            end
         end else begin
            if (dip2) begin
               if (blk2 > thr2) begin
                  dip2 = 0;
                  want_second = 0;
                  transit = onset2 - onset1;
                  done = 1;
               end
            end else if (blk2 <= thr2) begin
               dip2 = 1;
               onset2 = d.time_ms;
               if (delay2 == '0)
                  delay2 = cfg_delay2;
            end
         end
      end
      blk1 = '0;
      blk2 = '0;
      // count down the freeze timers
      if (delay1 != '0) begin
         delay1 = delay1 - 7'd1;
         if (delay1 == '0)
            frz1 = 10'd1;
      end
      if (frz2 != '0) begin
         frz2 = frz2 - 10'd1;
         frz1 = frz2;
      end
      if (delay2 != '0) begin
         delay2 = delay2 - 7'd1;
         if (delay2 == '0)
            frz2 = cfg_hold;
      end
      r.trace_one = t1[15:0];
      r.trace_one_write = w1;
      r.trace_two = t2[15:0];
      r.trace_two_write = w2;
      r.baseline_ready = known1;
      r.transit_done = done;
      r.transit_ms = transit;
      r.baseline_one_value = base1;
      r.baseline_two_value = base2;
      return 1;
   endfunction

   // drive one sample beat and hold it until taken
   task automatic send_sample(dstt_pkg::req_type d, bit typed, dstt_pkg::rsp_type want);
      dstt_pkg::rsp_type r;
      while (!quiet && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do
         @(posedge clock);
      while (req_stall);
      if (predict_block(d, r))
         pending_blocks.push_back(typed ? want : r);
   endtask

   // hold off the sender until every block result has come back
   task automatic wait_results(bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_blocks.size() != 0)
         @(posedge clock);
      if (settle)
         repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all eight registers from next_cfg, one per cycle
   task automatic write_registers();
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= IDX_BITS'(i);
         csr_data  <= next_cfg[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      cfg_blocks = next_cfg[dstt_pkg::CSR_BASELINE_BLOCKS][7:0];
      cfg_min_sum = next_cfg[dstt_pkg::CSR_MIN_BASELINE_SUM];
      cfg_drift = next_cfg[dstt_pkg::CSR_DRIFT_LIMIT][15:0];
      cfg_scale = next_cfg[dstt_pkg::CSR_TRACE_SCALE][7:0];
      cfg_offset = next_cfg[dstt_pkg::CSR_TRACE2_OFFSET][7:0];
      cfg_delay1 = next_cfg[dstt_pkg::CSR_FREEZE1_DELAY][6:0];
      cfg_delay2 = next_cfg[dstt_pkg::CSR_FREEZE2_DELAY][6:0];
      cfg_hold = next_cfg[dstt_pkg::CSR_FREEZE_HOLD][9:0];
      @(posedge clock);
   endtask

   task automatic set_registers(int blocks, int min_sum, int drift, int scale, int offset,
                                int d1, int d2, int hold);
      next_cfg[dstt_pkg::CSR_BASELINE_BLOCKS]  = 24'(blocks);
      next_cfg[dstt_pkg::CSR_MIN_BASELINE_SUM] = 24'(min_sum);
      next_cfg[dstt_pkg::CSR_DRIFT_LIMIT]      = 24'(drift);
      next_cfg[dstt_pkg::CSR_TRACE_SCALE]      = 24'(scale);
      next_cfg[dstt_pkg::CSR_TRACE2_OFFSET]    = 24'(offset);
      next_cfg[dstt_pkg::CSR_FREEZE1_DELAY]    = 24'(d1);
      next_cfg[dstt_pkg::CSR_FREEZE2_DELAY]    = 24'(d2);
      next_cfg[dstt_pkg::CSR_FREEZE_HOLD]      = 24'(hold);
      write_registers();
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endtask

   // result side: random stall, compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      dstt_pkg::rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blocks.size() == 0) begin
            $error("result beat with no block expected");
            fails++;
         end else begin
            w = pending_blocks.pop_front();
            check_field("trace_one", w.trace_one, rsp_data.trace_one);
            check_field("trace_one_write", w.trace_one_write, rsp_data.trace_one_write);
            check_field("trace_two", w.trace_two, rsp_data.trace_two);
            check_field("trace_two_write", w.trace_two_write, rsp_data.trace_two_write);
            check_field("baseline_ready", w.baseline_ready, rsp_data.baseline_ready);
            check_field("transit_done", w.transit_done, rsp_data.transit_done);
            check_field("transit_ms", w.transit_ms, rsp_data.transit_ms);
            check_field("baseline_one_value", w.baseline_one_value,
                        rsp_data.baseline_one_value);
            check_field("baseline_two_value", w.baseline_two_value,
                        rsp_data.baseline_two_value);
         end
      end
      rsp_stall <= !quiet && $urandom_range(0, 99) < 34;
   end

   function automatic logic [11:0] jitter(int level, int span);
      int v;
      v = level + $urandom_range(0, 2 * span) - span;
      return v < 0 ? 12'd0 : (v > 4095 ? 12'hFFF : 12'(v));
   endfunction

   initial begin
      row_type rows[$];
      row_type row;
      dstt_pkg::req_type d;
      logic [31:0] now;
      int lvl1, lvl2, mode, blocks, extra;

      clear_predictor();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks: typed results only while the baseline is still unknown
      row = '{SET_NONE, 12'd0, 12'd0, 32'd0, 16, 1, '0};
      rows.push_back(row);
      row = '{SET_NONE, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 16, 1, '0};
      rows.push_back(row);
      row = '{SET_LEARN, 12'd2000, 12'd1500, 32'd100, 16, 0, '0};
      repeat (4) rows.push_back(row);
      row = '{SET_NONE, 12'd1000, 12'd1500, 32'd250, 16, 0, '0};
      rows.push_back(row);
      row = '{SET_NONE, 12'd2000, 12'd1500, 32'd300, 16, 0, '0};
      rows.push_back(row);
      row = '{SET_NONE, 12'd2000, 12'd500, 32'd410, 16, 0, '0};
      rows.push_back(row);
      row = '{SET_NONE, 12'd2000, 12'd1500, 32'd500, 16, 0, '0};
      rows.push_back(row);
      // a window mean of zero gives a zero baseline and a saturated trace
      row = '{SET_ZERO_BASE, 12'd1, 12'd1, 32'd600, 1, 0, '0};
      rows.push_back(row);
      row = '{SET_NONE, 12'd0, 12'd0, 32'd601, 31, 0, '0};
      rows.push_back(row);
      row = '{SET_NONE, 12'd4095, 12'd4095, 32'd700, 16, 0, '0};
      rows.push_back(row);

      foreach (rows[i]) begin
         if (rows[i].setting != SET_NONE)
            wait_results(1);
         if (rows[i].setting == SET_LEARN)
            set_registers(4, 0, 100, 60, 3, 2, 1, 3);
         else if (rows[i].setting == SET_ZERO_BASE)
            set_registers(2, 0, 65535, 255, 0, 0, 0, 0);
         d.sample_one = rows[i].s1;
         d.sample_two = rows[i].s2;
         for (int k = 0; k < rows[i].rep; k++) begin
            d.time_ms = rows[i].t + 32'(k);
            send_sample(d, rows[i].typed && k == rows[i].rep - 1, rows[i].want);
         end
      end

      // random phases, each with its own register setting
      for (int p = 0; p < 8; p++) begin
         wait_results(1);
         quiet = (p == 4);
         if (p == 0)
            set_registers(1, 0, 0, 1, 0, 0, 0, 0);
         else if (p == 1)
            set_registers(2, 16777215, 65535, 255, 255, 127, 127, 1023);
         else if (p == 2)
            set_registers(255, 0, 65535, 255, 255, 3, 2, 5);
         else
            set_registers(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 400),
                          $urandom_range(1, 255), $urandom_range(0, 255),
                          $urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 8),
                          $urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 8),
                          $urandom_range(0, 4) == 0 ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 12));
         now = $urandom;
         lvl1 = $urandom_range(200, 4095);
         lvl2 = $urandom_range(200, 4095);
         blocks = (p == 2) ? 20 : 8;
         extra = (p >= 3) ? $urandom_range(0, 5) : 0;
         for (int b = 0; b < blocks * 16 + extra; b++) begin
            // pick the shape of each block: steady, dips, noise or all zero
            if (b % 16 == 0)
               mode = $urandom_range(0, 9);
            if (p == 6 && b == 48)
               wait_results(0);
            d.sample_one = jitter(lvl1, 6);
            d.sample_two = jitter(lvl2, 6);
            if (mode == 5 || mode == 6)
               d.sample_one = jitter(lvl1 * 7 / 10, 6);
            if (mode == 7 || mode == 6)
               d.sample_two = jitter(lvl2 * 6 / 10, 6);
            if (mode == 8) begin
               d.sample_one = 12'($urandom);
               d.sample_two = 12'($urandom);
            end
            if (mode == 9) begin
               d.sample_one = '0;
               d.sample_two = '0;
            end
            now = now + 32'($urandom_range(1, 40));
            d.time_ms = ($urandom_range(0, 49) == 0) ? $urandom : now;
            send_sample(d, 0, '0);
         end
      end

      quiet = 1'b0;
      wait_results(1);
      if (fails == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
